/* hdl/bole_pkg.sv */
package bole_pkg;

   localparam int WORD_W = 32;
   localparam int POS_W  = 4;
   localparam int OCC_W  = 5;

   typedef enum logic [2:0] {
      OP_INSERT       = 3'd0,
      OP_REMOVE       = 3'd1,
      OP_FIND         = 3'd2,
      OP_REMOVE_MATCH = 3'd3,
      OP_REPLACE      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_MATCH     = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN
   } state_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic shr;   // take left neighbor (insert front)
      logic shl;   // take right neighbor (remove)
      logic load;  // take replacement word
      logic cmp;   // capture match flag
      logic clr;   // drop match flag
   } cell_ctrl_type;

endpackage

/* hdl/bole_cell.sv */
module bole_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  bole_pkg::cell_ctrl_type       ctrl,
   input  logic                          occupied,
   input  logic [bole_pkg::WORD_W-1:0]   key,
   input  logic [bole_pkg::WORD_W-1:0]   left_data,
   input  logic [bole_pkg::WORD_W-1:0]   right_data,
   input  logic [bole_pkg::WORD_W-1:0]   new_data,
   output logic [bole_pkg::WORD_W-1:0]   data,
   output logic                          match
);
   import bole_pkg::*;

   logic [WORD_W-1:0] data_ff, data_in;
   logic              match_ff, match_in;

   always_comb begin
      if (ctrl.shr) begin
         data_in = left_data;
      end else if (ctrl.shl) begin
         data_in = right_data;
      end else if (ctrl.load) begin
         data_in = new_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_comb begin
      if (ctrl.cmp) begin
         match_in = occupied && (data_ff == key);
      end else if (ctrl.clr) begin
         match_in = 1'b0;
      end else begin
         match_in = match_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

/* hdl/bounded_ordered_list_engine.sv */
// Insert, remove, full and empty results load the output register from the EXEC state, once
// it is free; find, remove-match and replace capture match flags in EXEC, then show their
// first result from SCAN and further matches one per cycle while the output register is free.
// A new request is taken only in IDLE, after the current one is done, as set by the
// three-state sequencer and the single output register.
// Reset: synchronous, active high; clears the fill count, sequencer, match flags and rsp_tvalid.
module bounded_ordered_list_engine #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] value, [63:32] new_value
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] position, [8:4] occupancy, [15:9] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast
);
   import bole_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int PosW = $clog2(DEPTH);

   // sequencer and list bookkeeping
   state_type          state_ff, state_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic [2:0]         op_ff;
   logic [WORD_W-1:0]  key_ff, nval_ff;

   // output register; the sequencer holds while a result word waits here
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [POS_W-1:0]   rsp_pos_ff;
   logic [OCC_W-1:0]   rsp_occ_ff;
   logic               rsp_last_ff;

   logic               out_free;
   logic               emit;
   status_type         emit_status;
   logic [POS_W-1:0]   emit_pos;
   logic               emit_last;
   logic [OCC_W-1:0]   emit_occ;
   logic [31:0]        cnt_ext, pos_ext;

   // the chain
   cell_ctrl_type      ctrl_w [DEPTH];
   logic [WORD_W-1:0]  data_w [DEPTH];
   logic [DEPTH-1:0]   match_w;
   logic [DEPTH-1:0]   occ_w;
   logic [DEPTH-1:0]   rest_w;
   logic [PosW-1:0]    hit_pos;
   logic               any_hit;
   logic               full, empty;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign full       = (count_ff == CntW'(DEPTH));
   assign empty      = (count_ff == '0);

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [WORD_W-1:0] left_d, right_d;
         if (g == 0) begin : g_head
            assign left_d = key_ff;
         end else begin : g_body
            assign left_d = data_w[g-1];
         end
         if (g == DEPTH - 1) begin : g_tail
            assign right_d = data_w[g];
         end else begin : g_mid
            assign right_d = data_w[g+1];
         end
         assign occ_w[g] = (32'(g) < 32'(count_ff));

         bole_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl_w[g]),
            .occupied   (occ_w[g]),
            .key        (key_ff),
            .left_data  (left_d),
            .right_data (right_d),
            .new_data   (nval_ff),
            .data       (data_w[g]),
            .match      (match_w[g])
         );
      end
   endgenerate

   // lowest matching cell is the next result
   always_comb begin
      hit_pos = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (match_w[i]) begin
            hit_pos = PosW'(i);
         end
      end
   end

   assign any_hit = |match_w;
   assign rest_w  = match_w & ~(DEPTH'(1) << hit_pos);
   assign pos_ext = 32'(hit_pos);

   // next state, chain control and result word
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      emit        = 1'b0;
      emit_status = ST_DONE;
      emit_pos    = '0;
      emit_last   = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         ctrl_w[i] = '0;
      end

      case (state_ff)
         S_IDLE: begin
            // drop unused operation codes right here
            if (req_tvalid && (req_tuser <= OP_REPLACE)) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (op_ff == OP_INSERT) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (full) begin
                     emit_status = ST_FULL;
                  end else begin
                     for (int i = 0; i < DEPTH; i++) begin
                        ctrl_w[i].shr = 1'b1;
                     end
                     count_in = count_ff + CntW'(1);
                  end
               end
            end else if (empty) begin
               if (out_free) begin
                  emit        = 1'b1;
                  emit_status = ST_EMPTY;
                  state_in    = S_IDLE;
               end
            end else if (op_ff == OP_REMOVE) begin
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  for (int i = 0; i < DEPTH; i++) begin
                     ctrl_w[i].shl = 1'b1;
                  end
                  count_in = count_ff - CntW'(1);
               end
            end else begin
               // capture match flags in every cell, then walk them
               for (int i = 0; i < DEPTH; i++) begin
                  ctrl_w[i].cmp = 1'b1;
               end
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (out_free) begin
               emit = 1'b1;
               if (!any_hit) begin
                  emit_status = ST_NOT_FOUND;
                  state_in    = S_IDLE;
               end else if (op_ff == OP_REMOVE_MATCH) begin
                  emit_status = ST_MATCH;
                  emit_pos    = pos_ext[POS_W-1:0];
                  count_in    = count_ff - CntW'(1);
                  state_in    = S_IDLE;
                  for (int i = 0; i < DEPTH; i++) begin
                     ctrl_w[i].shl = (PosW'(i) >= hit_pos);
                     ctrl_w[i].clr = 1'b1;
                  end
               end else begin
                  emit_status = ST_MATCH;
                  emit_pos    = pos_ext[POS_W-1:0];
                  emit_last   = (rest_w == '0);
                  for (int i = 0; i < DEPTH; i++) begin
                     if (PosW'(i) == hit_pos) begin
                        ctrl_w[i].clr  = 1'b1;
                        ctrl_w[i].load = (op_ff == OP_REPLACE);
                     end
                  end
                  if (rest_w == '0) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign cnt_ext  = 32'(count_in);
   assign emit_occ = cnt_ext[OCC_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the request word for the whole operation
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff   <= req_tuser;
         key_ff  <= req_tdata[31:0];
         nval_ff <= req_tdata[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_status_ff <= emit_status;
         rsp_pos_ff    <= emit_pos;
         rsp_occ_ff    <= emit_occ;
         rsp_last_ff   <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_occ_ff, rsp_pos_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* hdl/bole_checker.sv */
module bole_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import bole_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_MATCH) |-> (rsp_tdata[3:0] == 4'd0))
      else $error("position set on a non-match result");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_MATCH) |-> rsp_tlast)
      else $error("status result not marked last");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_EMPTY) |-> (rsp_tdata[8:4] == 5'd0))
      else $error("empty status with nonzero occupancy");

   // a taken operation with a used code closes the request side in the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser <= OP_REPLACE) |=> !req_tready)
      else $error("request taken while an operation runs");

endmodule

bind bounded_ordered_list_engine bole_port_checker u_bole_checker (.*);

/* tb/bole_checker.sv */
module bole_checker #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] value, [63:32] new_value
   input  logic [2:0]  req_tuser,   // [2:0] operation
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [3:0] position, [8:4] occupancy, [15:9] zero
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          pending
);

   timeunit 1ns;
   timeprecision 1ps;

   import bole_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [POS_W-1:0]   position;
      logic [OCC_W-1:0]   occupancy;
      logic               last;
   } list_result_type;

   // shadow copy of the list, front at index 0
   logic [WORD_W-1:0] cells [DEPTH];
   int                held;
   list_result_type   outstanding[$];

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, field, got, want);
      mismatches++;
   endtask

   function automatic void push_result(status_type st, int pos, bit fin);
      list_result_type r;
      r.status    = st;
      r.position  = POS_W'(pos);
      r.occupancy = OCC_W'(held);
      r.last      = fin;
      outstanding.push_back(r);
   endfunction

   // apply one request word to the shadow list and queue what it should produce
   task automatic apply_list_op(logic [2:0] code, logic [31:0] key, logic [31:0] repl);
      int i;
      int first;
      int hits;
      first = -1;
      hits  = 0;
      if (code > OP_REPLACE) return;
      if (code == OP_INSERT) begin
         if (held >= DEPTH) begin
            push_result(ST_FULL, 0, 1'b1);
         end else begin
            for (i = held; i > 0; i--) cells[i] = cells[i-1];
            cells[0] = key;
            held++;
            push_result(ST_DONE, 0, 1'b1);
         end
         return;
      end
      if (held == 0) begin
         push_result(ST_EMPTY, 0, 1'b1);
         return;
      end
      case (op_type'(code))
         OP_REMOVE: begin
            for (i = 0; i < held - 1; i++) cells[i] = cells[i+1];
            held--;
            push_result(ST_DONE, 0, 1'b1);
         end
         OP_REMOVE_MATCH: begin
            for (i = 0; i < held; i++)
               if (first < 0 && cells[i] == key) first = i;
            if (first < 0) begin
               push_result(ST_NOT_FOUND, 0, 1'b1);
            end else begin
               for (i = first; i < held - 1; i++) cells[i] = cells[i+1];
               held--;
               push_result(ST_MATCH, first, 1'b1);
            end
         end
         default: begin
            for (i = 0; i < held; i++) begin
               if (cells[i] == key) begin
                  if (code == OP_REPLACE) cells[i] = repl;
                  push_result(ST_MATCH, i, 1'b0);
                  hits++;
               end
            end
            if (hits == 0) push_result(ST_NOT_FOUND, 0, 1'b1);
            else outstanding[outstanding.size()-1].last = 1'b1;
         end
      endcase
   endtask

   task automatic check_result();
      list_result_type want;
      if (outstanding.size() == 0) begin
         report("unexpected word", {16'd0, rsp_tdata}, 32'd0);
         return;
      end
      want = outstanding.pop_front();
      if (rsp_tuser !== want.status)
         report("status", 32'(rsp_tuser), 32'(want.status));
      if (rsp_tdata[3:0] !== want.position)
         report("position", 32'(rsp_tdata[3:0]), 32'(want.position));
      if (rsp_tdata[8:4] !== want.occupancy)
         report("occupancy", 32'(rsp_tdata[8:4]), 32'(want.occupancy));
      if (rsp_tlast !== want.last)
         report("tlast", 32'(rsp_tlast), 32'(want.last));
      if (rsp_tdata[15:9] !== 7'd0)
         report("pad bits", 32'(rsp_tdata[15:9]), 32'd0);
   endtask

   // results of a word are never taken at the edge that takes the word, so check first, then predict
   always @(posedge clock) begin
      if (reset) begin
         outstanding.delete();
         held       = 0;
         mismatches = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (req_tvalid && req_tready) apply_list_op(req_tuser, req_tdata[31:0], req_tdata[63:32]);
      end
      pending <= outstanding.size();
   end

endmodule

/* tb/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bole_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_WORDS   = 80;
   localparam int PHASE_WORDS    = 20;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 24;
   // worst quiet stretch: the long hold plus a long stall and the block's own cycles
   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   typedef enum int {
      MODE_GROW,
      MODE_SEARCH,
      MODE_SHRINK
   } mix_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] value, [63:32] new_value
   logic [2:0]  req_tuser;   // [2:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [3:0] position, [8:4] occupancy, [15:9] zero
   logic [2:0]  rsp_tuser;   // [2:0] status
   logic        rsp_tlast;

   int          mismatches;
   int          pending;
   int          idle_cycles;
   bit          no_idle;        // set for stretches where neither side pauses
   bit          rsp_hold_req;   // ask the receiver for one long hold-off
   logic [31:0] value_pool [8];

   bounded_ordered_list_engine #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   bole_checker #(.DEPTH(DEPTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle) return 0;
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Draw from the pool most of the time so searches hit; otherwise any 32-bit pattern.
   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 3) != 0) return value_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Weight the operations by the mode of the current phase.
   function automatic op_type pick_op(mix_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (r < 55) return OP_INSERT;
            if (r < 65) return OP_REMOVE;
            if (r < 77) return OP_FIND;
            if (r < 87) return OP_REMOVE_MATCH;
            return OP_REPLACE;
         end
         MODE_SEARCH: begin
            if (r < 25) return OP_INSERT;
            if (r < 40) return OP_REMOVE;
            if (r < 60) return OP_FIND;
            if (r < 80) return OP_REMOVE_MATCH;
            return OP_REPLACE;
         end
         default: begin
            if (r < 10) return OP_INSERT;
            if (r < 50) return OP_REMOVE;
            if (r < 65) return OP_FIND;
            if (r < 90) return OP_REMOVE_MATCH;
            return OP_REPLACE;
         end
      endcase
   endfunction

   // Offer one request word and return at the edge that takes it. Ready is sampled
   // at the falling edge, where every output of the block has settled.
   task automatic send_word(logic [2:0] code, logic [31:0] key, logic [31:0] repl);
      int gap;
      bit taken;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {repl, key};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Receiver: hold ready for a while, then drop it for a random pause. On request
   // take one long hold-off so the block fills and backs up its input.
   initial begin
      int stall;
      bit hold_done;
      hold_done  = 1'b0;
      rsp_tready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         stall = pick_gap();
         if (rsp_hold_req && !hold_done) begin
            stall     = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watchdog: count edges at which neither channel moves a word.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      mix_mode_type mode;
      int           phase;
      int           sent;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= '0;
      no_idle      = 1'b0;
      rsp_hold_req = 1'b0;
      value_pool[0] = 32'h0000_0000;
      value_pool[1] = 32'hFFFF_FFFF;
      value_pool[2] = 32'h7FFF_FFFF;
      value_pool[3] = 32'h8000_0000;
      value_pool[4] = 32'h0000_0001;
      for (int i = 5; i < 8; i++) value_pool[i] = $urandom;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Every search and remove on an empty list reports empty.
      send_word(OP_REMOVE,       32'd0, 32'd0);
      send_word(OP_FIND,         32'd0, 32'd0);
      send_word(OP_REMOVE_MATCH, 32'd0, 32'd0);
      send_word(OP_REPLACE,      32'd0, 32'hFFFF_FFFF);

      // Extremes of the value field, with a duplicate at the front.
      send_word(OP_INSERT, 32'h7FFF_FFFF, 32'd0);
      send_word(OP_INSERT, 32'h8000_0000, 32'd0);
      send_word(OP_INSERT, 32'hFFFF_FFFF, 32'd0);
      send_word(OP_INSERT, 32'h0000_0000, 32'd0);
      send_word(OP_INSERT, 32'h0000_0000, 32'd0);

      // Multiple matches, no match, replace, then first-match removal with and without a hit.
      send_word(OP_FIND,         32'h0000_0000, 32'd0);
      send_word(OP_FIND,         32'h0000_3039, 32'd0);
      send_word(OP_REPLACE,      32'h0000_0000, 32'h8000_0000);
      send_word(OP_FIND,         32'h8000_0000, 32'd0);
      send_word(OP_REMOVE_MATCH, 32'h8000_0000, 32'd0);
      send_word(OP_REMOVE_MATCH, 32'h0000_3039, 32'd0);
      send_word(OP_REMOVE,       32'd0, 32'd0);

      // Unused operation codes produce nothing.
      send_word(OP_UNUSED_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_word(OP_UNUSED_HI, 32'h0000_0000, 32'h0000_0000);

      // Three entries remain: fill to the top, then one more insert is refused as full.
      repeat (DEPTH - 3 + 1) send_word(OP_INSERT, 32'h5A5A_5A5A, 32'd0);
      send_word(OP_FIND,         32'h5A5A_5A5A, 32'd0);
      send_word(OP_REPLACE,      32'h5A5A_5A5A, 32'hA5A5_A5A5);
      send_word(OP_REMOVE_MATCH, 32'hA5A5_A5A5, 32'd0);

      // Random phases cycle grow, search and shrink so the list swings between
      // empty and full; ignored codes are sprinkled in as noise and not counted.
      for (phase = 0; phase < RANDOM_WORDS / PHASE_WORDS; phase++) begin
         mode    = mix_mode_type'(phase % 3);
         no_idle = ($urandom_range(0, 3) == 0);
         sent    = 0;
         while (sent < PHASE_WORDS) begin
            // Hold off the receiver once while the list is well populated.
            if (phase == 1 && sent == 5) rsp_hold_req = 1'b1;
            if ($urandom_range(0, 99) < 4) begin
               send_word(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom, $urandom);
            end else begin
               send_word(pick_op(mode), pick_value(), pick_value());
               sent++;
            end
         end
      end
      req_tvalid <= 1'b0;
      no_idle    = 1'b0;

      // Drain: let the checker's count settle, wait for every result, then linger.
      @(posedge clock);
      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
